// ----- design/sobel_pkg.sv -----
// Shared types, constants and register codes for the RGB Sobel edge stream.
// Used by every module of the block; depends on nothing else.
package sobel_pkg;

   localparam int MAX_WIDTH_DEF   = 1024;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd800;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd600;

   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 3;
   localparam int PIX_W     = CHAN_W * NUM_CHAN;
   localparam int ROW_W     = 16;
   localparam int COL_OUT_W = 10;
   localparam int GRAD_W    = 11;
   localparam int SQ_W      = 21;
   localparam int PROD_W    = 22;
   localparam int ROOT_SQ_W = 16;

   localparam logic [SQ_W-1:0]   ROOT_CLAMP_LIMIT = 21'd65025;
   localparam logic [CHAN_W-1:0] EDGE_MAX         = 8'd255;
   localparam logic [CHAN_W-1:0] ROOT_FIRST_BIT   = 8'h80;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type REG_IMAGE_WIDTH  = 1'd0;
   localparam csr_index_type REG_IMAGE_HEIGHT = 1'd1;

   typedef struct packed {
      logic [ROW_W-1:0]     row_cur;
      logic [ROW_W-1:0]     row_up;
      logic [COL_OUT_W-1:0] col_cur;
      logic [COL_OUT_W-1:0] col_left;
      logic [COL_OUT_W-1:0] col_last;
      logic                 has_a;
      logic                 mag_a;
      logic                 has_b;
      logic                 has_c;
   } pos_type;

   typedef struct packed {
      pos_type                          pos;
      logic [NUM_CHAN-1:0][GRAD_W-1:0] gx;
      logic [NUM_CHAN-1:0][GRAD_W-1:0] gy;
   } task_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_SQUARE,
      B_ROOT,
      B_EMIT
   } back_state_type;

endpackage

// ----- design/sobel_if.sv -----
// Valid/ready channel interfaces for pixels in and edge results out.
// Payload widths come from sobel_pkg.
interface sobel_req_if;
   logic                          valid;
   logic                          ready;
   logic [sobel_pkg::CHAN_W-1:0]  red;
   logic [sobel_pkg::CHAN_W-1:0]  green;
   logic [sobel_pkg::CHAN_W-1:0]  blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface sobel_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sobel_pkg::ROW_W-1:0]     out_row;
   logic [sobel_pkg::COL_OUT_W-1:0] out_col;
   logic [sobel_pkg::CHAN_W-1:0]    edge_red;
   logic [sobel_pkg::CHAN_W-1:0]    edge_green;
   logic [sobel_pkg::CHAN_W-1:0]    edge_blue;
   logic                            run_last;

   modport source (output valid, output out_row, output out_col, output edge_red,
                   output edge_green, output edge_blue, output run_last, input ready);
   modport sink (input valid, input out_row, input out_col, input edge_red,
                 input edge_green, input edge_blue, input run_last, output ready);
endinterface

// ----- design/sobel_front.sv -----
// Front end: registers, raster counters, line memory, 3x3 window and gradients.
// Pushes one task per pixel that releases results; uses sobel_pkg and sobel_req_if.
module sobel_front #(
   parameter int MAX_WIDTH   = sobel_pkg::MAX_WIDTH_DEF,
   parameter int QUEUE_DEPTH = sobel_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  sobel_pkg::csr_index_type          csr_index,
   input  logic [sobel_pkg::CSR_DATA_W-1:0]  csr_wdata,
   sobel_req_if.sink                         req_chan,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_free,
   output logic                              q_push,
   output sobel_pkg::task_type               q_data
);
   import sobel_pkg::*;

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int CMPW  = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
   localparam int FREEW = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTW  = 2 * PIX_W;

   function automatic logic [COL_OUT_W-1:0] fit_col(input logic [WW-1:0] v);
      logic [WW+COL_OUT_W-1:0] wide;
      wide = (WW + COL_OUT_W)'(v);
      return wide[COL_OUT_W-1:0];
   endfunction

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [AW-1:0]           col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;

   logic                    s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]        s1_px_ff, s1_px_in;
   logic [AW-1:0]           s1_col_ff, s1_col_in;
   pos_type                 s1_pos_ff, s1_pos_in;
   logic                    byp_ff, byp_in;
   logic [ENTW-1:0]         byp_data_ff, byp_data_in;
   logic [ENTW-1:0]         mem_rd_ff;
   logic [ENTW-1:0]         line_mem [MAX_WIDTH];

   logic                    s2_valid_ff, s2_valid_in;
   pos_type                 s2_pos_ff, s2_pos_in;
   logic [PIX_W-1:0]        win_ff [3][3];
   logic [PIX_W-1:0]        win_in [3][3];

   logic                    accept;
   logic [CMPW-1:0]         width_ext;
   logic [WW-1:0]           w_eff, w_last, col_next;
   logic [HEIGHT_REG_W-1:0] h_eff;
   logic [AW-1:0]           c_cur;
   logic [ROW_W-1:0]        r_tmp, r_cur;
   logic [ROW_W:0]          row_next;
   logic [FREEW-1:0]        inflight;
   logic [ENTW-1:0]         entry;
   logic [ENTW-1:0]         wr_data;
   pos_type                 pos_new;
   logic [GRAD_W-1:0]       px_g [3][3];

   assign inflight       = FREEW'(s1_valid_ff) + FREEW'(s2_valid_ff);
   assign req_chan.ready = q_free > inflight;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in = csr_wdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_wdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      width_ext = CMPW'(width_ff);
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (width_ext > CMPW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = width_ext[WW-1:0];
      end
      w_last = w_eff - WW'(1);
      h_eff  = (height_ff == '0) ? HEIGHT_REG_W'(1) : height_ff;

      if (WW'(col_ff) >= w_eff) begin
         c_cur = '0;
         r_tmp = row_ff + ROW_W'(1);
      end else begin
         c_cur = col_ff;
         r_tmp = row_ff;
      end
      r_cur = (r_tmp >= h_eff) ? '0 : r_tmp;

      col_next = WW'(c_cur) + WW'(1);
      row_next = (ROW_W + 1)'(r_cur) + (ROW_W + 1)'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (col_next == w_eff) begin
            col_in = '0;
            row_in = (row_next == (ROW_W + 1)'(h_eff)) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[AW-1:0];
            row_in = r_cur;
         end
      end

      pos_new.row_cur  = r_cur;
      pos_new.row_up   = r_cur - ROW_W'(1);
      pos_new.col_cur  = fit_col(WW'(c_cur));
      pos_new.col_left = fit_col(WW'(c_cur) - WW'(1));
      pos_new.col_last = fit_col(w_last);
      pos_new.has_a    = (r_cur != '0) && (c_cur != '0);
      pos_new.mag_a    = (r_cur >= ROW_W'(2)) && (WW'(c_cur) >= WW'(2));
      pos_new.has_b    = (r_cur != '0) && (WW'(c_cur) == w_last);
      pos_new.has_c    = r_cur == (h_eff - HEIGHT_REG_W'(1));
   end

   always_comb begin
      s1_valid_in = accept;
      s1_px_in    = {req_chan.blue, req_chan.green, req_chan.red};
      s1_col_in   = c_cur;
      s1_pos_in   = pos_new;

      entry       = byp_ff ? byp_data_ff : mem_rd_ff;
      wr_data     = {entry[PIX_W-1:0], s1_px_ff};
      byp_in      = accept && s1_valid_ff && (s1_col_ff == c_cur);
      byp_data_in = wr_data;

      win_in = win_ff;
      if (s1_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i][0] = win_ff[i][1];
            win_in[i][1] = win_ff[i][2];
         end
         win_in[0][2] = entry[ENTW-1:PIX_W];
         win_in[1][2] = entry[PIX_W-1:0];
         win_in[2][2] = s1_px_ff;
      end

      s2_valid_in = s1_valid_ff;
      s2_pos_in   = s1_pos_ff;
   end

   always_comb begin
      q_data.pos = s2_pos_ff;
      for (int k = 0; k < NUM_CHAN; k++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               px_g[i][j] = GRAD_W'(win_ff[i][j][CHAN_W*k +: CHAN_W]);
            end
         end
         q_data.gx[k] = (px_g[0][2] + (px_g[1][2] << 1) + px_g[2][2])
                      - (px_g[0][0] + (px_g[1][0] << 1) + px_g[2][0]);
         q_data.gy[k] = (px_g[2][0] + (px_g[2][1] << 1) + px_g[2][2])
                      - (px_g[0][0] + (px_g[0][1] << 1) + px_g[0][2]);
      end
      q_push = s2_valid_ff && (s2_pos_ff.has_a || s2_pos_ff.has_b || s2_pos_ff.has_c);
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= wr_data;
      end
      if (accept) begin
         mem_rd_ff <= line_mem[c_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         byp_ff      <= byp_in;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_px_ff    <= s1_px_in;
      s1_col_ff   <= s1_col_in;
      s1_pos_ff   <= s1_pos_in;
      byp_data_ff <= byp_data_in;
      s2_pos_ff   <= s2_pos_in;
   end

endmodule

// ----- design/sobel_queue.sv -----
// Short task queue between the front end and the back end.
// Holds sobel_pkg::task_type entries; depends on sobel_pkg only.
module sobel_queue #(
   parameter int QUEUE_DEPTH = sobel_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_push,
   input  sobel_pkg::task_type               q_data,
   input  logic                              q_pop,
   output sobel_pkg::task_type               q_head,
   output logic                              q_empty,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_free
);
   import sobel_pkg::*;

   localparam int PW   = $clog2(QUEUE_DEPTH);
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   task_type        slot_mem [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;

   assign q_head  = slot_mem[rd_ptr_ff];
   assign q_empty = count_ff == '0;
   assign q_free  = CNTW'(QUEUE_DEPTH) - count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CNTW'(q_push) - CNTW'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_mem[wr_ptr_ff] <= q_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/sobel_back.sv -----
// Back end: sum of squares, bit-serial clamped square root and result sequencing.
// Drives the result channel through an output register; uses sobel_pkg and sobel_rsp_if.
module sobel_back (
   input  logic                clock,
   input  logic                reset,
   input  sobel_pkg::task_type q_head,
   input  logic                q_empty,
   output logic                q_pop,
   sobel_rsp_if.source         rsp_chan
);
   import sobel_pkg::*;

   back_state_type       state_ff, state_in;
   task_type             task_ff, task_in;
   logic [SQ_W-1:0]      sq_ff [NUM_CHAN];
   logic [SQ_W-1:0]      sq_in [NUM_CHAN];
   logic [CHAN_W-1:0]    root_ff [NUM_CHAN];
   logic [CHAN_W-1:0]    root_in [NUM_CHAN];
   logic [CHAN_W-1:0]    bit_ff, bit_in;
   logic [2:0]           pend_ff, pend_in;

   logic                 out_valid_ff, out_valid_in;
   logic [ROW_W-1:0]     out_row_ff, out_row_in;
   logic [COL_OUT_W-1:0] out_col_ff, out_col_in;
   logic [CHAN_W-1:0]    out_edge_ff [NUM_CHAN];
   logic [CHAN_W-1:0]    out_edge_in [NUM_CHAN];
   logic                 out_last_ff, out_last_in;

   logic                 load_out;
   logic [2:0]           pend_left;
   logic signed [GRAD_W-1:0] gx_s [NUM_CHAN];
   logic signed [GRAD_W-1:0] gy_s [NUM_CHAN];
   logic signed [PROD_W-1:0] sum_s [NUM_CHAN];
   logic [CHAN_W-1:0]    trial [NUM_CHAN];
   logic [ROOT_SQ_W-1:0] trial_sq [NUM_CHAN];
   logic [CHAN_W-1:0]    edge_val [NUM_CHAN];

   always_comb begin
      q_pop    = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         B_IDLE: q_pop = !q_empty;
         B_EMIT: load_out = !out_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   always_comb begin
      if (pend_ff[0]) begin
         pend_left = pend_ff & 3'b110;
      end else if (pend_ff[1]) begin
         pend_left = pend_ff & 3'b100;
      end else begin
         pend_left = 3'b000;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               state_in = q_head.pos.mag_a ? B_SQUARE : B_EMIT;
            end
         end
         B_SQUARE: state_in = B_ROOT;
         B_ROOT: begin
            if (bit_ff[0]) begin
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (load_out && (pend_left == 3'b000)) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      task_in = q_pop ? q_head : task_ff;
      pend_in = pend_ff;
      if (q_pop) begin
         pend_in = {q_head.pos.has_c, q_head.pos.has_b, q_head.pos.has_a};
      end else if (load_out) begin
         pend_in = pend_left;
      end

      bit_in = bit_ff;
      if (state_ff == B_SQUARE) begin
         bit_in = ROOT_FIRST_BIT;
      end else if (state_ff == B_ROOT) begin
         bit_in = bit_ff >> 1;
      end

      for (int k = 0; k < NUM_CHAN; k++) begin
         gx_s[k]     = $signed(task_ff.gx[k]);
         gy_s[k]     = $signed(task_ff.gy[k]);
         sum_s[k]    = PROD_W'(gx_s[k]) * PROD_W'(gx_s[k])
                     + PROD_W'(gy_s[k]) * PROD_W'(gy_s[k]);
         trial[k]    = root_ff[k] | bit_ff;
         trial_sq[k] = ROOT_SQ_W'(trial[k]) * ROOT_SQ_W'(trial[k]);
         sq_in[k]    = (state_ff == B_SQUARE) ? sum_s[k][SQ_W-1:0] : sq_ff[k];
         root_in[k]  = root_ff[k];
         if (state_ff == B_SQUARE) begin
            root_in[k] = '0;
         end else if ((state_ff == B_ROOT) && (SQ_W'(trial_sq[k]) <= sq_ff[k])) begin
            root_in[k] = trial[k];
         end
         edge_val[k] = (sq_ff[k] >= ROOT_CLAMP_LIMIT) ? EDGE_MAX : root_ff[k];
      end
   end

   always_comb begin
      out_valid_in = load_out ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_edge_in  = out_edge_ff;
      out_last_in  = out_last_ff;
      if (load_out) begin
         out_last_in = pend_left == 3'b000;
         for (int k = 0; k < NUM_CHAN; k++) begin
            out_edge_in[k] = '0;
         end
         if (pend_ff[0]) begin
            out_row_in = task_ff.pos.row_up;
            out_col_in = task_ff.pos.col_left;
            if (task_ff.pos.mag_a) begin
               out_edge_in = edge_val;
            end
         end else if (pend_ff[1]) begin
            out_row_in = task_ff.pos.row_up;
            out_col_in = task_ff.pos.col_last;
         end else begin
            out_row_in = task_ff.pos.row_cur;
            out_col_in = task_ff.pos.col_cur;
         end
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.out_row    = out_row_ff;
   assign rsp_chan.out_col    = out_col_ff;
   assign rsp_chan.edge_red   = out_edge_ff[0];
   assign rsp_chan.edge_green = out_edge_ff[1];
   assign rsp_chan.edge_blue  = out_edge_ff[2];
   assign rsp_chan.run_last   = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff     <= task_in;
      sq_ff       <= sq_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
      out_edge_ff <= out_edge_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ----- design/sobel_edge_rgb_stream_top.sv -----
// Channel    Dir  Payload                                          Handshake
// req_chan   in   red, green, blue                                 valid / ready
// rsp_chan   out  out_row, out_col, edge_red/green/blue, run_last  valid / ready
// csr_*      in   csr_index, csr_wdata                             csr_we, never stalls
//
// The front end takes one pixel per cycle while the task queue has room for it and
// for the two items in its pipeline; tasks are pushed to the queue from the s2 register.
// The back end fetches a task in B_IDLE, then for an interior pixel forms the sums of
// squares in B_SQUARE and the bit-serial root in B_ROOT, then loads each result in B_EMIT;
// it takes a new task only after the last result is loaded, so it sets the sustained rate.
// Reset is synchronous and clears the counters, window, queue and output register;
// the line memory is not cleared. A stalled result holds the output register, the
// queue fills behind it, and req_chan.ready then drops.
module sobel_edge_rgb_stream_top #(
   parameter int MAX_WIDTH   = sobel_pkg::MAX_WIDTH_DEF,
   parameter int QUEUE_DEPTH = sobel_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  sobel_pkg::csr_index_type          csr_index,
   input  logic [sobel_pkg::CSR_DATA_W-1:0]  csr_wdata,
   sobel_req_if.sink                         req_chan,
   sobel_rsp_if.source                       rsp_chan
);
   import sobel_pkg::*;

   localparam int FREEW = $clog2(QUEUE_DEPTH + 1);

   logic             q_push;
   task_type         q_data;
   logic             q_pop;
   task_type         q_head;
   logic             q_empty;
   logic [FREEW-1:0] q_free;

   sobel_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .q_free    (q_free),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   sobel_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_empty (q_empty),
      .q_free  (q_free)
   );

   sobel_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_free != '0))
      else $error("task pushed into a full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("task popped from an empty queue");

   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> (q_free != '0))
      else $error("item accepted with no queue room");
`endif

endmodule
